@@ design/cvs_pkg.sv @@
package cvs_pkg;

    typedef enum logic [1:0] {
        OP_VAR_WRITE  = 2'd0,
        OP_PAIR_WRITE = 2'd1,
        OP_SELECT     = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        MODE_FIRST    = 4'd0,
        MODE_LAST     = 4'd1,
        MODE_MIN_DOM  = 4'd2,
        MODE_MAX_DEG  = 4'd3,
        MODE_DYN_DEG  = 4'd4,
        MODE_WDEG     = 4'd5,
        MODE_DOM_DEG  = 4'd6,
        MODE_DOM_DDEG = 4'd7,
        MODE_DOM_WDEG = 4'd8
    } mode_t;

    localparam logic CFG_MODE       = 1'b0;
    localparam logic CFG_MAX_DOMAIN = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_EVAL,
        ST_NEXT,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic start;
        logic sum_step;
        logic div_start;
        logic div_step;
        logic eval;
        logic next_var;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic row_done;
        logic last_var;
        logic need_sum;
        logic need_div;
        logic div_done;
    } status_t;

endpackage

@@ design/cvs_ctrl.sv @@
module cvs_ctrl
    import cvs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_go,
    input  logic    out_free,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    clearing
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        clearing = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clearing = 1'b1;
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (in_go)
                begin
                    cmd.start = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                // skip the row walk when the mode needs no pair degree
                if (!status.need_sum)
                begin
                    state_next = status.need_div ? ST_DIV : ST_EVAL;
                    cmd.div_start = status.need_div;
                end
                else
                begin
                    cmd.sum_step = 1'b1;
                    if (status.row_done)
                    begin
                        state_next = status.need_div ? ST_DIV : ST_EVAL;
                    end
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EVAL;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (status.last_var)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.next_var = 1'b1;
                    state_next = ST_SUM;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_load_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> state_reg == ST_OUT)
        else $error("result loaded outside output state");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> state_reg == ST_SUM)
        else $error("select did not start scan");
    a_clear_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && status.clear_done) |=> state_reg == ST_IDLE)
        else $error("clear pass did not finish");
`endif

endmodule

@@ design/cvs_dp.sv @@
module cvs_dp
    import cvs_pkg::*;
#(
    parameter int NUM_VARS    = 64,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic        wr_en,
    input  logic [1:0]  op,
    input  logic [5:0]  var_index,
    input  logic [5:0]  other_index,
    input  logic        is_unassigned,
    input  logic [15:0] dom_count,
    input  logic [5:0]  static_degree,
    input  logic        linked,
    input  logic [15:0] fail_weight,
    input  logic [3:0]  mode,
    input  logic [15:0] max_domain,
    output status_t     status,
    output logic [5:0]  res_index,
    output logic        res_none
);

    localparam int IW    = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int PW    = 2 * IW;
    localparam int DEPTH = 1 << PW;
    localparam int SW    = WEIGHT_BITS + IW + 1;
    localparam int QW    = 16;

    logic [NUM_VARS-1:0] free_reg;
    logic [15:0] dom_mem [NUM_VARS];
    logic [5:0]  deg_mem [NUM_VARS];
    logic [WEIGHT_BITS:0] pair_mem [DEPTH];

    logic [PW:0] clr_reg;
    logic [IW-1:0] i_reg;
    logic [IW-1:0] rd_addr;
    logic [IW:0] j_reg;
    logic [SW-1:0] sum_reg;
    logic [WEIGHT_BITS:0] pair_rd;
    logic rd_valid_reg;
    logic [IW-1:0] rd_j_reg;
    logic [15:0] dom_rd;
    logic [5:0] deg_rd;
    logic [SW-1:0] rem_reg;
    logic [QW-1:0] quo_reg;
    logic [4:0] dcnt_reg;
    logic [31:0] bestv_reg;
    logic [IW-1:0] best_reg;
    logic any_reg;
    logic [3:0] m;
    logic minimize;
    logic [IW-1:0] a_idx, b_idx;
    logic a_ok, b_ok;

    assign m = (mode > MODE_DOM_WDEG) ? MODE_FIRST : mode;
    assign minimize = (m == MODE_MIN_DOM) || (m >= MODE_DOM_DEG);
    assign status.need_sum = (m == MODE_DYN_DEG) || (m == MODE_WDEG) ||
                             (m == MODE_DOM_DDEG) || (m == MODE_DOM_WDEG);
    assign status.need_div = (m >= MODE_DOM_DEG);
    assign status.clear_done = clr_reg[PW];
    assign status.last_var = (int'(i_reg) == NUM_VARS - 1);
    assign status.row_done = rd_valid_reg && (int'(rd_j_reg) == NUM_VARS - 1);
    assign status.div_done = (dcnt_reg == 5'd0);

    assign a_idx = IW'(var_index);
    assign b_idx = IW'(other_index);
    assign a_ok  = 32'(var_index) < NUM_VARS;
    assign b_ok  = 32'(other_index) < NUM_VARS;

    // record read address follows the next value of the variable index
    assign rd_addr = cmd.start ? '0 : (cmd.next_var ? i_reg + 1'b1 : i_reg);

    // variable records
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '0;
        end
        else if (wr_en && op == OP_VAR_WRITE && a_ok)
        begin
            free_reg[a_idx] <= is_unassigned;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && op == OP_VAR_WRITE && a_ok)
        begin
            dom_mem[a_idx] <= dom_count;
            deg_mem[a_idx] <= static_degree;
        end
        dom_rd <= dom_mem[rd_addr];
        deg_rd <= deg_mem[rd_addr];
    end

    // pair table: {link, weight}, cleared after reset one entry a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step && !clr_reg[PW])
        begin
            pair_mem[clr_reg[PW-1:0]] <= '0;
        end
        else if (wr_en && op == OP_PAIR_WRITE && a_ok && b_ok)
        begin
            pair_mem[{a_idx, b_idx}] <= {linked, WEIGHT_BITS'(fail_weight)};
        end
        pair_rd <= pair_mem[{i_reg, j_reg[IW-1:0]}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_step && !clr_reg[PW])
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // row walk: address j_reg, registered data follows in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg <= '0;
            rd_valid_reg <= 1'b0;
            rd_j_reg <= '0;
            sum_reg <= '0;
        end
        else if (cmd.start || cmd.next_var)
        begin
            j_reg <= '0;
            rd_valid_reg <= 1'b0;
            sum_reg <= '0;
        end
        else if (cmd.sum_step)
        begin
            if (int'(j_reg) < NUM_VARS)
            begin
                j_reg <= j_reg + 1'b1;
            end
            rd_valid_reg <= int'(j_reg) < NUM_VARS;
            rd_j_reg <= j_reg[IW-1:0];
            if (rd_valid_reg && free_reg[rd_j_reg] && pair_rd[WEIGHT_BITS])
            begin
                sum_reg <= sum_reg + ((m == MODE_WDEG || m == MODE_DOM_WDEG) ?
                    SW'(pair_rd[WEIGHT_BITS-1:0]) : SW'(1));
            end
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [SW-1:0] divisor;
    logic [SW:0] trial;
    assign divisor = (m == MODE_DOM_DEG) ? SW'(deg_rd) : sum_reg;
    assign trial = {rem_reg, quo_reg[QW-1]} - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cmd.div_start || (cmd.sum_step && status.row_done && status.need_div))
        begin
            dcnt_reg <= 5'(QW);
            rem_reg <= '0;
            quo_reg <= dom_rd;
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg - 1'b1;
            if (!trial[SW])
            begin
                rem_reg <= trial[SW-1:0];
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[SW-2:0], quo_reg[QW-1]};
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
        end
    end

    logic [31:0] v;
    always_comb
    begin
        unique case (m)
            MODE_MIN_DOM: v = 32'(dom_rd);
            MODE_MAX_DEG: v = 32'(deg_rd);
            MODE_DYN_DEG, MODE_WDEG: v = 32'(sum_reg);
            MODE_DOM_DEG, MODE_DOM_DDEG, MODE_DOM_WDEG:
                v = (divisor == '0) ? 32'(max_domain) : 32'(quo_reg);
            default: v = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            any_reg <= 1'b0;
            best_reg <= '0;
            bestv_reg <= '0;
            res_index <= '0;
            res_none <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                i_reg <= '0;
                any_reg <= 1'b0;
                best_reg <= '0;
                bestv_reg <= minimize ? 32'(max_domain) : '0;
            end
            else if (cmd.next_var)
            begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.eval && free_reg[i_reg])
            begin
                any_reg <= 1'b1;
                if (m == MODE_FIRST)
                begin
                    if (!any_reg)
                    begin
                        best_reg <= i_reg;
                    end
                end
                else if (m == MODE_LAST)
                begin
                    best_reg <= i_reg;
                end
                else if (minimize ? (v <= bestv_reg) : (v >= bestv_reg))
                begin
                    bestv_reg <= v;
                    best_reg <= i_reg;
                end
            end
            if (cmd.load_out)
            begin
                res_index <= any_reg ? 6'(best_reg) : 6'd0;
                res_none <= !any_reg;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_div_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval |-> (!status.need_div || status.div_done))
        else $error("ratio used before division done");
    a_no_write_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_step |-> !wr_en)
        else $error("table write during clear pass");
    a_none_index: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.load_out) && res_none |-> res_index == 6'd0)
        else $error("index set with no free variable");
`endif

endmodule

@@ design/csp_variable_selector_core.sv @@
// A select walks every variable in turn: a pair-table row walk in the dynamic and weighted
// degree modes and the dom/dynamic and dom/weighted degree modes, then the divider in the
// dom/degree, dom/dynamic and dom/weighted degree modes, then an evaluation step.
// One select is worked on at a time; input stalls until its result is loaded.
// Write items are taken whenever the input is not stalled. After reset a clearing pass
// zeroes all 2**(2*clog2(NUM_VARS)) pair-table entries; no item is accepted until then.
module csp_variable_selector_core
    import cvs_pkg::*;
#(
    parameter int NUM_VARS    = 64,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [5:0]  var_index,
    input  logic [5:0]  other_index,
    input  logic        is_unassigned,
    input  logic [15:0] dom_count,
    input  logic [5:0]  static_degree,
    input  logic        linked,
    input  logic [15:0] fail_weight,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  chosen_index,
    output logic        none_free
);

    cmd_t cmd;
    status_t status;
    logic busy, clearing, in_xfer, out_free;
    logic [3:0] mode_reg;
    logic [15:0] max_domain_reg;
    logic out_valid_reg;
    logic [5:0] res_index;
    logic res_none;

    assign in_stall = busy;
    assign in_xfer = in_valid && !busy;
    assign cfg_ready = 1'b1;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign chosen_index = res_index;
    assign none_free = res_none;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_FIRST;
            max_domain_reg <= 16'hFFFF;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_MODE)
            begin
                mode_reg <= cfg_data[3:0];
            end
            else
            begin
                max_domain_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    cvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_go    (in_xfer && op == OP_SELECT),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .clearing (clearing)
    );

    cvs_dp #(
        .NUM_VARS    (NUM_VARS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .wr_en         (in_xfer && !clearing),
        .op            (op),
        .var_index     (var_index),
        .other_index   (other_index),
        .is_unassigned (is_unassigned),
        .dom_count     (dom_count),
        .static_degree (static_degree),
        .linked        (linked),
        .fail_weight   (fail_weight),
        .mode          (mode_reg),
        .max_domain    (max_domain_reg),
        .status        (status),
        .res_index     (res_index),
        .res_none      (res_none)
    );

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(chosen_index))
        else $error("stalled result changed");
    a_no_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> in_stall)
        else $error("input taken during clear pass");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("result overwrote pending result");
`endif

endmodule

@@ sim/tb_csp_variable_selector_core.sv @@
module tb_csp_variable_selector_core;
    import cvs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV          = 64;
    localparam int IDLE_LIMIT  = 30000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 40;

    typedef struct packed {
        logic [5:0] idx;
        logic       nf;
    } pick_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [5:0]  var_index;
    logic [5:0]  other_index;
    logic        is_unassigned;
    logic [15:0] dom_count;
    logic [5:0]  static_degree;
    logic        linked;
    logic [15:0] fail_weight;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        out_valid;
    logic        out_stall;
    logic [5:0]  chosen_index;
    logic        none_free;

    // shadow copy of the selector tables and registers
    logic [3:0]  sh_mode;
    logic [15:0] sh_max_dom;
    logic        sh_free [NV];
    logic [15:0] sh_dom [NV];
    logic [5:0]  sh_deg [NV];
    logic        sh_link [NV*NV];
    logic [15:0] sh_weight [NV*NV];

    pick_t pick_q[$];
    int    err_cnt;
    int    send_gap_pct;
    int    stall_pct;
    bit    hold_req;
    int    hold_cnt;
    int    idle_cycles;

    csp_variable_selector_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .var_index     (var_index),
        .other_index   (other_index),
        .is_unassigned (is_unassigned),
        .dom_count     (dom_count),
        .static_degree (static_degree),
        .linked        (linked),
        .fail_weight   (fail_weight),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .chosen_index  (chosen_index),
        .none_free     (none_free)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint row_degree(int i, bit weighted);
        longint sum;
        sum = 0;
        for (int j = 0; j < NV; j++)
            if (sh_free[j] && sh_link[i*NV + j])
                sum += weighted ? longint'(sh_weight[i*NV + j]) : longint'(1);
        return sum;
    endfunction

    function automatic pick_t predict_pick();
        pick_t  res;
        logic [3:0] m;
        bit     any;
        bit     minimize;
        int     best;
        longint bestv;
        longint v;
        longint dg;
        m = (sh_mode > MODE_DOM_WDEG) ? MODE_FIRST : sh_mode;
        minimize = (m == MODE_MIN_DOM) || (m >= MODE_DOM_DEG);
        bestv = minimize ? longint'(sh_max_dom) : 0;
        any = 0;
        best = 0;
        for (int i = 0; i < NV; i++)
        begin
            if (!sh_free[i])
                continue;
            if (m == MODE_FIRST)
            begin
                if (!any)
                    best = i;
                any = 1;
                continue;
            end
            any = 1;
            if (m == MODE_LAST)
            begin
                best = i;
                continue;
            end
            case (m)
                MODE_MIN_DOM: v = longint'(sh_dom[i]);
                MODE_MAX_DEG: v = longint'(sh_deg[i]);
                MODE_DYN_DEG: v = row_degree(i, 1'b0);
                MODE_WDEG:    v = row_degree(i, 1'b1);
                default:
                begin
                    if (m == MODE_DOM_DEG)
                        dg = longint'(sh_deg[i]);
                    else
                        dg = row_degree(i, m == MODE_DOM_WDEG);
                    v = (dg == 0) ? longint'(sh_max_dom) : longint'(sh_dom[i]) / dg;
                end
            endcase
            if (minimize ? (v <= bestv) : (v >= bestv))
            begin
                bestv = v;
                best = i;
            end
        end
        res.idx = any ? 6'(best) : 6'd0;
        res.nf  = !any;
        return res;
    endfunction

    // update shadow tables for one accepted transfer
    task automatic apply_item(op_t o, logic [5:0] a, logic [5:0] b, logic fr,
                              logic [15:0] d, logic [5:0] g, logic lk,
                              logic [15:0] w);
        case (o)
            OP_VAR_WRITE:
            begin
                sh_free[a] = fr;
                sh_dom[a]  = d;
                sh_deg[a]  = g;
            end
            OP_PAIR_WRITE:
            begin
                sh_link[a*NV + b]   = lk;
                sh_weight[a*NV + b] = w;
            end
            OP_SELECT: pick_q.push_back(predict_pick());
            default: ;
        endcase
    endtask

    task automatic send_item(op_t o, logic [5:0] a, logic [5:0] b, logic fr,
                             logic [15:0] d, logic [5:0] g, logic lk,
                             logic [15:0] w);
        if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= o;
        var_index     <= a;
        other_index   <= b;
        is_unassigned <= fr;
        dom_count     <= d;
        static_degree <= g;
        linked        <= lk;
        fail_weight   <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_item(o, a, b, fr, d, g, lk, w);
    endtask

    task automatic write_var(logic [5:0] a, logic fr, logic [15:0] d, logic [5:0] g);
        send_item(OP_VAR_WRITE, a, 6'($urandom), fr, d, g, 1'($urandom), 16'($urandom));
    endtask

    task automatic write_pair(logic [5:0] a, logic [5:0] b, logic lk, logic [15:0] w);
        send_item(OP_PAIR_WRITE, a, b, 1'($urandom), 16'($urandom), 6'($urandom), lk, w);
    endtask

    task automatic do_select();
        send_item(OP_SELECT, 6'($urandom), 6'($urandom), 1'($urandom), 16'($urandom),
                  6'($urandom), 1'($urandom), 16'($urandom));
    endtask

    // stop offering and wait until every pending pick has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pick_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_MODE)
            sh_mode = data[3:0];
        else
            sh_max_dom = data;
        @(posedge clk);
    endtask

    task automatic set_config(logic [3:0] m, logic [15:0] md);
        drain();
        write_reg(CFG_MODE, {12'd0, m});
        write_reg(CFG_MAX_DOMAIN, md);
    endtask

    task automatic test_directed();
        send_gap_pct = 0;
        stall_pct    = 0;
        do_select();                       // nothing free yet
        send_item(OP_NONE, 6'd5, 6'd5, 1'b1, 16'd1, 6'd1, 1'b1, 16'd1);
        write_var(6'd0, 1'b1, 16'hFFFF, 6'd63);
        write_var(6'd63, 1'b1, 16'd0, 6'd0);
        write_var(6'd21, 1'b1, 16'd100, 6'd5);
        write_var(6'd42, 1'b1, 16'd100, 6'd0);
        write_var(6'd10, 1'b0, 16'd7, 6'd2);
        write_pair(6'd0, 6'd63, 1'b1, 16'hFFFF);
        write_pair(6'd63, 6'd0, 1'b1, 16'd1);
        write_pair(6'd21, 6'd42, 1'b1, 16'd0);
        write_pair(6'd21, 6'd21, 1'b1, 16'd3);
        write_pair(6'd42, 6'd63, 1'b0, 16'd9);
        for (int m = MODE_FIRST; m <= MODE_DOM_WDEG; m++)
        begin
            set_config(m[3:0], 16'hFFFF);
            do_select();
        end
        set_config(4'd15, 16'd0);          // unknown mode acts as first free
        do_select();
        // every free domain above the ceiling: none beats it, index 0 with none_free low
        write_var(6'd63, 1'b1, 16'd50, 6'd0);
        set_config(MODE_MIN_DOM, 16'd1);
        do_select();
        set_config(MODE_DOM_DEG, 16'd0);
        do_select();
    endtask

    function automatic logic [5:0] rand_index();
        return ($urandom_range(99) < 60) ? 6'($urandom_range(7) * 9) : 6'($urandom);
    endfunction

    task automatic test_random(int n, int gap_pct, int stl_pct);
        int          kind;
        logic [15:0] md;
        send_gap_pct = gap_pct;
        stall_pct    = stl_pct;
        for (int k = 0; k < n; k++)
        begin
            if (k % 12 == 0)
            begin
                case ($urandom_range(3))
                    0: md = 16'd0;
                    1: md = 16'hFFFF;
                    default: md = 16'($urandom);
                endcase
                set_config(($urandom_range(9) == 0) ? 4'($urandom_range(9, 15))
                                                    : 4'($urandom_range(8)), md);
            end
            kind = int'($urandom_range(99));
            if (kind < 45)
                write_var(rand_index(), $urandom_range(99) < 70,
                          $urandom_range(1) ? 16'($urandom_range(30)) : 16'($urandom),
                          6'($urandom));
            else if (kind < 75)
                write_pair(rand_index(), rand_index(), $urandom_range(99) < 70,
                           $urandom_range(1) ? 16'($urandom_range(20)) : 16'($urandom));
            else if (kind < 95)
                do_select();
            else
                send_item(OP_NONE, 6'($urandom), 6'($urandom), 1'($urandom),
                          16'($urandom), 6'($urandom), 1'($urandom), 16'($urandom));
        end
    endtask

    // receiver holds off while selects keep coming, so the input stalls
    task automatic test_backpressure();
        set_config(MODE_MIN_DOM, 16'hFFFF);
        send_gap_pct = 0;
        stall_pct    = 0;
        hold_req = 1'b1;
        for (int k = 0; k < 12; k++)
            do_select();
    endtask

    // receiver side
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        pick_t exp_pick;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pick_q.size() == 0)
            begin
                $display("%0t: unexpected result idx=%0d none_free=%0b",
                         $realtime, chosen_index, none_free);
                err_cnt++;
            end
            else
            begin
                exp_pick = pick_q.pop_front();
                if (chosen_index !== exp_pick.idx)
                begin
                    $display("%0t: chosen_index expected %0d actual %0d",
                             $realtime, exp_pick.idx, chosen_index);
                    err_cnt++;
                end
                if (none_free !== exp_pick.nf)
                begin
                    $display("%0t: none_free expected %0b actual %0b",
                             $realtime, exp_pick.nf, none_free);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        err_cnt      = 0;
        idle_cycles  = 0;
        hold_req     = 1'b0;
        hold_cnt     = 0;
        send_gap_pct = 0;
        stall_pct    = 0;
        sh_mode      = MODE_FIRST;
        sh_max_dom   = 16'hFFFF;
        for (int i = 0; i < NV; i++)
        begin
            sh_free[i] = 1'b0;
            sh_dom[i]  = '0;
            sh_deg[i]  = '0;
        end
        for (int i = 0; i < NV*NV; i++)
        begin
            sh_link[i]   = 1'b0;
            sh_weight[i] = '0;
        end
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        op            <= OP_NONE;
        var_index     <= '0;
        other_index   <= '0;
        is_unassigned <= 1'b0;
        dom_count     <= '0;
        static_degree <= '0;
        linked        <= 1'b0;
        fail_weight   <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_MODE;
        cfg_data      <= '0;
        out_stall     <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(36, 34, 51);
        test_random(36, 51, 34);
        test_random(36, 0, 0);
        test_backpressure();
        drain();

        if (err_cnt == 0 && pick_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
